### rtl/full_duplex_uart_8n1_defines.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and arst_n in scope.
`ifndef FULL_DUPLEX_UART_8N1_DEFINES_SVH
`define FULL_DUPLEX_UART_8N1_DEFINES_SVH

// Same-cycle implication.
`define UFD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define UFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ufd_pkg.sv
package ufd_pkg;

	// Widths of the item fields
	localparam int ByteW = 8;
	localparam int TickW = 8;
	localparam int RxTimerW = 9;

	// Default frame length and bit time
	localparam int DataBits = 8;
	localparam logic [TickW-1:0] TicksPerBitReset = 8'd26;
	localparam logic [TickW-1:0] MinBitTime = 8'd2;

	// Receiver phases
	typedef enum logic [1:0] {
		RX_ARMED = 2'd0,
		RX_RECV  = 2'd1,
		RX_DONE  = 2'd2
	} rx_phase_t;

endpackage

### rtl/ufd_in_if.sv
interface ufd_in_if;
	logic                     valid;
	logic                     ready;
	logic                     rx_line;
	logic                     send_valid;
	logic [ufd_pkg::ByteW-1:0] send_byte;

	modport source (output valid, rx_line, send_valid, send_byte, input ready);
	modport sink (input valid, rx_line, send_valid, send_byte, output ready);
	modport monitor (input valid, ready, rx_line, send_valid, send_byte);
endinterface

### rtl/ufd_out_if.sv
interface ufd_out_if;
	logic                     valid;
	logic                     ready;
	logic                     tx_line;
	logic                     tx_busy;
	logic                     rx_valid;
	logic [ufd_pkg::ByteW-1:0] rx_byte;

	modport source (output valid, tx_line, tx_busy, rx_valid, rx_byte, input ready);
	modport sink (input valid, tx_line, tx_busy, rx_valid, rx_byte, output ready);
	modport monitor (input valid, ready, tx_line, tx_busy, rx_valid, rx_byte);
endinterface

### rtl/full_duplex_uart_8n1.sv
// An accepted tick item passes the input register and then the result register, and is held
// longer only while the result side stalls.
// Throughput: one tick item per cycle while the result side does not stall; the transmitter and
// receiver state update in a single pass between the input register and the result register.
// Reset: arst_n low clears the state at once: line idle high, receiver armed, bit time 26.
module full_duplex_uart_8n1 #(
	parameter int DATA_BITS = ufd_pkg::DataBits
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ufd_pkg::TickW-1:0] cfg_wdata,
	ufd_in_if.sink                    in_ch,
	ufd_out_if.source                 out_ch
);

	localparam int CntW = $clog2(DATA_BITS + 2);
	localparam int ExtW = (DATA_BITS > ufd_pkg::ByteW) ? DATA_BITS : ufd_pkg::ByteW;

	// Configuration and pipeline control
	logic [ufd_pkg::TickW-1:0] ticks_q;
	logic                      valid_s1;
	logic                      rx_line_s1;
	logic                      send_valid_s1;
	logic [ufd_pkg::ByteW-1:0] send_byte_s1;
	logic                      out_valid_q;
	logic                      out_free;
	logic                      adv_s1;

	// Transceiver state
	logic [ufd_pkg::ByteW-1:0]    tx_shift_q, tx_shift_nx;
	logic [CntW-1:0]              tx_cnt_q, tx_cnt_nx;
	logic [ufd_pkg::TickW-1:0]    tx_timer_q, tx_timer_nx;
	logic                         tx_level_q, tx_level_nx;
	logic                         tx_active_q, tx_active_nx;
	ufd_pkg::rx_phase_t           rx_phase_q, rx_phase_nx;
	logic [DATA_BITS-1:0]         rx_shift_q, rx_shift_nx;
	logic [CntW-1:0]              rx_cnt_q, rx_cnt_nx;
	logic [ufd_pkg::RxTimerW-1:0] rx_timer_q, rx_timer_nx;

	// Per-item combinational values
	logic [ufd_pkg::TickW-1:0]    bit_t;
	logic [ufd_pkg::RxTimerW:0]   three_t;
	logic                         rx_valid_nx;
	logic [ExtW-1:0]              rx_ext;
	logic [ufd_pkg::ByteW-1:0]    rx_byte_nx;

	// Result register
	logic                      tx_line_q;
	logic                      tx_busy_q;
	logic                      rx_valid_q;
	logic [ufd_pkg::ByteW-1:0] rx_byte_q;

	assign out_free = !out_valid_q || out_ch.ready;
	assign adv_s1 = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;

	// Hold the bit time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= ufd_pkg::TicksPerBitReset;
		end else if (cfg_we) begin
			ticks_q <= cfg_wdata;
		end
	end

	// Advance the valid flags of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Capture the input item
	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			rx_line_s1 <= in_ch.rx_line;
			send_valid_s1 <= in_ch.send_valid;
			send_byte_s1 <= in_ch.send_byte;
		end
	end

	// Compute the next transmitter and receiver state for one tick
	always_comb begin
		bit_t = (ticks_q < ufd_pkg::MinBitTime) ? ufd_pkg::MinBitTime : ticks_q;
		three_t = {2'b00, bit_t} + {1'b0, bit_t, 1'b0};

		tx_shift_nx = tx_shift_q;
		tx_cnt_nx = tx_cnt_q;
		tx_timer_nx = tx_timer_q;
		tx_level_nx = tx_level_q;
		tx_active_nx = tx_active_q;

		// Step the current frame
		if (tx_active_q) begin
			if (tx_timer_q != '0) begin
				tx_timer_nx = tx_timer_q - 1'b1;
			end
			if (tx_timer_nx == '0) begin
				if (tx_cnt_q < CntW'(DATA_BITS)) begin
					tx_level_nx = tx_shift_q[0];
					tx_shift_nx = tx_shift_q >> 1;
					tx_cnt_nx = tx_cnt_q + 1'b1;
					tx_timer_nx = bit_t;
				end else if (tx_cnt_q == CntW'(DATA_BITS)) begin
					tx_level_nx = 1'b1;
					tx_cnt_nx = tx_cnt_q + 1'b1;
					tx_timer_nx = bit_t;
				end else begin
					tx_active_nx = 1'b0;
					tx_level_nx = 1'b1;
				end
			end
		end

		// Start a new frame when idle; drop the request otherwise
		if (!tx_active_nx && send_valid_s1) begin
			tx_shift_nx = send_byte_s1;
			tx_cnt_nx = '0;
			tx_timer_nx = bit_t;
			tx_level_nx = 1'b0;
			tx_active_nx = 1'b1;
		end

		rx_phase_nx = rx_phase_q;
		rx_shift_nx = rx_shift_q;
		rx_cnt_nx = rx_cnt_q;
		rx_timer_nx = rx_timer_q;
		rx_valid_nx = 1'b0;

		case (rx_phase_q)
			ufd_pkg::RX_ARMED: begin
				// A low line is the start edge; first sample 1.5 bit times out
				if (!rx_line_s1) begin
					rx_timer_nx = three_t[ufd_pkg::RxTimerW:1];
					rx_shift_nx = '0;
					rx_cnt_nx = '0;
					rx_phase_nx = ufd_pkg::RX_RECV;
				end
			end
			ufd_pkg::RX_RECV: begin
				if (rx_timer_q != '0) begin
					rx_timer_nx = rx_timer_q - 1'b1;
				end
				if (rx_timer_nx == '0) begin
					if (DATA_BITS > 1) begin
						rx_shift_nx = {rx_line_s1, rx_shift_q[DATA_BITS-1:1]};
					end else begin
						rx_shift_nx = DATA_BITS'(rx_line_s1);
					end
					rx_cnt_nx = rx_cnt_q + 1'b1;
					if (rx_cnt_nx >= CntW'(DATA_BITS)) begin
						rx_phase_nx = ufd_pkg::RX_DONE;
						rx_valid_nx = 1'b1;
					end else begin
						rx_timer_nx = ufd_pkg::RxTimerW'(bit_t);
					end
				end
			end
			default: begin
				// Rearm once the line is high again
				if (rx_line_s1) begin
					rx_phase_nx = ufd_pkg::RX_ARMED;
				end
			end
		endcase

		rx_ext = ExtW'(rx_shift_nx);
		rx_byte_nx = rx_valid_nx ? rx_ext[ufd_pkg::ByteW-1:0] : '0;
	end

	// Update the state register once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_shift_q <= '0;
			tx_cnt_q <= '0;
			tx_timer_q <= '0;
			tx_level_q <= 1'b1;
			tx_active_q <= 1'b0;
			rx_phase_q <= ufd_pkg::RX_ARMED;
			rx_shift_q <= '0;
			rx_cnt_q <= '0;
			rx_timer_q <= '0;
		end else if (adv_s1) begin
			tx_shift_q <= tx_shift_nx;
			tx_cnt_q <= tx_cnt_nx;
			tx_timer_q <= tx_timer_nx;
			tx_level_q <= tx_level_nx;
			tx_active_q <= tx_active_nx;
			rx_phase_q <= rx_phase_nx;
			rx_shift_q <= rx_shift_nx;
			rx_cnt_q <= rx_cnt_nx;
			rx_timer_q <= rx_timer_nx;
		end
	end

	// Load the result item
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tx_line_q <= tx_level_nx;
			tx_busy_q <= tx_active_nx;
			rx_valid_q <= rx_valid_nx;
			rx_byte_q <= rx_byte_nx;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.tx_line = tx_line_q;
	assign out_ch.tx_busy = tx_busy_q;
	assign out_ch.rx_valid = rx_valid_q;
	assign out_ch.rx_byte = rx_byte_q;

endmodule

### rtl/ufd_checker.sv
`include "full_duplex_uart_8n1_defines.svh"

module ufd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      tx_line,
	input logic                      tx_busy,
	input logic                      rx_valid,
	input logic [ufd_pkg::ByteW-1:0] rx_byte
);

	logic                      stalled;
	logic [ufd_pkg::ByteW+2:0] payload;

	assign stalled = out_valid && !out_ready;
	assign payload = {tx_line, tx_busy, rx_valid, rx_byte};

	// An offered result item stays offered
	`UFD_ASSERT_NEXT(a_out_valid_holds, stalled, out_valid, "result item withdrawn while stalled")

	// A stalled result item keeps its payload
	`UFD_ASSERT_NEXT(a_out_payload_holds, stalled, $stable(payload), "result payload changed")

	// The received byte reads zero unless a byte completes
	`UFD_ASSERT_IMPL(a_rx_byte_zero, out_valid && !rx_valid, rx_byte == '0, "rx_byte set, no rx_valid")

	// An idle transmitter holds the line high
	`UFD_ASSERT_IMPL(a_tx_idle_high, out_valid && !tx_busy, tx_line, "tx_line low while idle")

endmodule

bind full_duplex_uart_8n1 ufd_checker u_ufd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.tx_line   (out_ch.tx_line),
	.tx_busy   (out_ch.tx_busy),
	.rx_valid  (out_ch.rx_valid),
	.rx_byte   (out_ch.rx_byte)
);

### tb/tb_full_duplex_uart_8n1.sv
`timescale 1ns / 1ps

typedef struct packed {
	logic                      tx_line;
	logic                      tx_busy;
	logic                      rx_valid;
	logic [ufd_pkg::ByteW-1:0] rx_byte;
} uart_tick_result_t;

// Tracks the transmitter and receiver state tick by tick and holds the
// line levels and received bytes that the block still owes.
class uart_tick_tracker;
	bit [ufd_pkg::TickW-1:0]    bit_ticks;
	bit [ufd_pkg::ByteW-1:0]    tx_data;
	bit [3:0]                   tx_sent;
	bit [ufd_pkg::TickW-1:0]    tx_left;
	bit                         tx_level;
	bit                         tx_active;
	ufd_pkg::rx_phase_t         rx_phase;
	bit [ufd_pkg::ByteW-1:0]    rx_data;
	bit [3:0]                   rx_count;
	bit [ufd_pkg::RxTimerW-1:0] rx_left;
	uart_tick_result_t          due_results[$];
	int                         errors;

	function new();
		bit_ticks = ufd_pkg::TicksPerBitReset;
		tx_data = '0;
		tx_sent = '0;
		tx_left = '0;
		tx_level = 1'b1;
		tx_active = 1'b0;
		rx_phase = ufd_pkg::RX_ARMED;
		rx_data = '0;
		rx_count = '0;
		rx_left = '0;
		errors = 0;
	endfunction

	function void set_bit_ticks(bit [ufd_pkg::TickW-1:0] value);
		bit_ticks = value;
	endfunction

	// Advance both halves by one tick and queue the levels they show after it.
	function void note_tick(bit line, bit req, bit [ufd_pkg::ByteW-1:0] data);
		bit [ufd_pkg::TickW-1:0] t;
		uart_tick_result_t       r;
		t = (bit_ticks < ufd_pkg::MinBitTime) ? ufd_pkg::MinBitTime : bit_ticks;
		r = '0;

		// shift out start, data and stop bits
		if (tx_active) begin
			if (tx_left > 0)
				tx_left--;
			if (tx_left == 0) begin
				if (tx_sent < ufd_pkg::DataBits) begin
					tx_level = tx_data[0];
					tx_data = tx_data >> 1;
					tx_sent++;
					tx_left = t;
				end else if (tx_sent == ufd_pkg::DataBits) begin
					tx_level = 1'b1;
					tx_sent++;
					tx_left = t;
				end else begin
					tx_active = 1'b0;
					tx_level = 1'b1;
				end
			end
		end
		// take a new byte only when idle, drop it otherwise
		if (!tx_active && req) begin
			tx_data = data;
			tx_sent = '0;
			tx_left = t;
			tx_level = 1'b0;
			tx_active = 1'b1;
		end

		// sample mid-bit, starting one and a half bits after the edge
		case (rx_phase)
			ufd_pkg::RX_ARMED: begin
				if (!line) begin
					rx_left = (3 * t) >> 1;
					rx_data = '0;
					rx_count = '0;
					rx_phase = ufd_pkg::RX_RECV;
				end
			end
			ufd_pkg::RX_RECV: begin
				if (rx_left > 0)
					rx_left--;
				if (rx_left == 0) begin
					rx_data = {line, rx_data[ufd_pkg::ByteW-1:1]};
					rx_count++;
					if (rx_count >= ufd_pkg::DataBits) begin
						rx_phase = ufd_pkg::RX_DONE;
						r.rx_valid = 1'b1;
						r.rx_byte = rx_data;
					end else begin
						rx_left = t;
					end
				end
			end
			default: begin
				if (line)
					rx_phase = ufd_pkg::RX_ARMED;
			end
		endcase

		r.tx_line = tx_level;
		r.tx_busy = tx_active;
		due_results.push_back(r);
	endfunction

	function void report_field(string field, logic [7:0] want, logic [7:0] got);
		$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
		errors++;
	endfunction

	// Compare one result against the oldest owed one.
	function void check_result(uart_tick_result_t got);
		uart_tick_result_t want;
		if (due_results.size() == 0) begin
			$display("%0t: result with nothing owed, expected none, got %h", $time, got);
			errors++;
			return;
		end
		want = due_results.pop_front();
		if (got.tx_line !== want.tx_line)
			report_field("tx_line", want.tx_line, got.tx_line);
		if (got.tx_busy !== want.tx_busy)
			report_field("tx_busy", want.tx_busy, got.tx_busy);
		if (got.rx_valid !== want.rx_valid)
			report_field("rx_valid", want.rx_valid, got.rx_valid);
		if (got.rx_byte !== want.rx_byte)
			report_field("rx_byte", want.rx_byte, got.rx_byte);
	endfunction
endclass

module tb_full_duplex_uart_8n1;
	localparam int CycleLimit = 400000;
	localparam int IdlePct = 23;
	localparam int NoisePct = 15;
	localparam int HoldCycles = 400;
	localparam int DrainCycles = 4;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [ufd_pkg::TickW-1:0] cfg_wdata;

	ufd_in_if  in_ch ();
	ufd_out_if out_ch ();

	uart_tick_tracker tracker;
	bit               quiet = 1'b0;
	bit               hold_req = 1'b0;
	int               stall_left = 0;
	int               cycles = 0;

	full_duplex_uart_8n1 i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bound the run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb_full_duplex_uart_8n1: done, errors");
			$finish;
		end
	end

	// Check accepted results and drive ready, with random stalls and one long hold.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				tracker.check_result({out_ch.tx_line, out_ch.tx_busy, out_ch.rx_valid,
					out_ch.rx_byte});
			if (hold_req) begin
				stall_left = HoldCycles;
				hold_req = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= arst_n && (quiet || $urandom_range(99) >= IdlePct);
			end
		end
	end

	// Offer one tick item, idling at random first, and hold it until taken.
	task automatic send_tick(input logic line, input logic req,
			input logic [ufd_pkg::ByteW-1:0] data);
		while (!quiet && $urandom_range(99) < IdlePct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.rx_line <= line;
		in_ch.send_valid <= req;
		in_ch.send_byte <= data;
		do
			@(posedge clk);
		while (!in_ch.ready);
		tracker.note_tick(line, req, data);
	endtask

	// Put a well-formed 8N1 frame on the receive line, with random send requests.
	task automatic send_serial_frame(input logic [ufd_pkg::ByteW-1:0] data, input int t,
			input int req_pct);
		logic [9:0] frame_bits;
		frame_bits = {1'b1, data, 1'b0};
		for (int i = 0; i < 10; i++)
			repeat (t) send_tick(frame_bits[i], $urandom_range(99) < req_pct, 8'($urandom));
	endtask

	// Drive a stuck-low or random receive line to break framing.
	task automatic send_line_noise(input int n, input int req_pct);
		bit stuck;
		stuck = $urandom_range(1);
		repeat (n)
			send_tick(stuck ? 1'b0 : 1'($urandom), $urandom_range(99) < req_pct,
				8'($urandom));
	endtask

	// Stop offering, wait until every owed result is in, then let the pipe settle.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (tracker.due_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic load_bit_ticks(input logic [ufd_pkg::TickW-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_bit_ticks(value);
	endtask

	// Mostly clean frames with idle gaps, now and then noise on the line.
	task automatic run_phase(input int t, input int frames);
		int req_pct;
		repeat (frames) begin
			case ($urandom_range(2))
				0: req_pct = 4;
				1: req_pct = 30;
				default: req_pct = 100;
			endcase
			repeat ($urandom_range(2 * t))
				send_tick(1'b1, $urandom_range(99) < req_pct, 8'($urandom));
			if (t <= 8 && $urandom_range(99) < NoisePct)
				send_line_noise($urandom_range(1, 4 * t), req_pct);
			else
				send_serial_frame(8'($urandom), t, req_pct);
		end
		repeat (2 * t) send_tick(1'b1, 1'b0, 8'($urandom));
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.rx_line = 1'b1;
		in_ch.send_valid = 1'b0;
		in_ch.send_byte = '0;
		out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Low line right after reset starts a receive; second request hits a busy sender.
		send_tick(1'b0, 1'b1, 8'hFF);
		send_tick(1'b0, 1'b1, 8'h00);
		send_tick(1'b1, 1'b1, 8'h5A);
		repeat (4) send_tick(1'b1, 1'b0, 8'h00);
		send_tick(1'b0, 1'b0, 8'hFF);
		// Reach the first sample, 1.5 bit times after the edge at the reset bit time.
		repeat (40) send_tick(1'b1, 1'b0, 8'h00);

		// Hold the request high so the next byte goes out on the tick the stop bit ends.
		load_bit_ticks(8'd2);
		repeat (21) send_tick(1'b1, 1'b1, 8'h00);
		hold_req = 1'b1;
		run_phase(2, 8);

		// Bit times below two act as two.
		load_bit_ticks(8'd0);
		run_phase(2, 4);
		load_bit_ticks(8'd1);
		run_phase(2, 4);

		load_bit_ticks(8'd3);
		run_phase(3, 4);

		quiet = 1'b1;
		load_bit_ticks(8'd5);
		run_phase(5, 3);
		quiet = 1'b0;

		load_bit_ticks(8'd4);
		run_phase(4, 2);

		// Longest bit time: start a frame and a receive, then watch the first ticks only.
		load_bit_ticks(8'hFF);
		send_tick(1'b0, 1'b1, 8'($urandom));
		repeat (8) send_tick(1'b1, 1'b1, 8'($urandom));

		drain_results();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("tb_full_duplex_uart_8n1: done, clean");
		else
			$display("tb_full_duplex_uart_8n1: done, errors");
		$finish;
	end
endmodule

### full_duplex_uart_8n1.f
+incdir+rtl
rtl/ufd_pkg.sv
rtl/ufd_in_if.sv
rtl/ufd_out_if.sv
rtl/full_duplex_uart_8n1.sv
rtl/ufd_checker.sv
tb/tb_full_duplex_uart_8n1.sv
